FILE: sv/sed_pkg.sv
`timescale 1ns / 1ps

package sed_pkg;

    localparam int TILE_W  = 16;
    localparam int PAL_W   = 5;
    localparam int SX_W    = 10;
    localparam int SY_W    = 11;
    localparam int PRIO_W  = 8;
    localparam int PART_W  = 3;

    localparam logic [PRIO_W-1:0] PRIO_MASK_NONE = 8'h00;
    localparam logic [PRIO_W-1:0] PRIO_MASK_MID  = 8'hf0;
    localparam logic [PRIO_W-1:0] PRIO_MASK_TOP  = 8'hfc;

    localparam logic [1:0] PRIO_LVL_NONE = 2'd0;
    localparam logic [1:0] PRIO_LVL_MID  = 2'd1;

    localparam logic [8:0]  X_WRAP   = 9'd320;
    localparam logic [8:0]  Y_WRAP   = 9'd256;
    localparam logic signed [SY_W-1:0] X_ORIGIN = 11'sd304;
    localparam logic signed [SY_W-1:0] Y_ORIGIN = 11'sd240;
    localparam logic signed [SY_W-1:0] X_LIMIT  = 11'sd320;
    localparam logic [SY_W-1:0] PART_PITCH = 11'd16;

    // Decoded sprite entry, handed from the decoder to the part sequencer
    typedef struct packed {
        logic                   drop;
        logic                   flip;
        logic                   mirror_x;
        logic                   mirror_y;
        logic                   entry_fy;
        logic [PAL_W-1:0]       palette;
        logic [PRIO_W-1:0]      prio_mask;
        logic [SX_W-1:0]        screen_x;
        logic [SY_W-1:0]        pos_y;
        logic [TILE_W-1:0]      base;
        logic [PART_W-1:0]      last_idx;
    } dec_t;

endpackage

FILE: sv/sed_entry_decode.sv
`timescale 1ns / 1ps

module sed_entry_decode (
    input  logic [15:0]   attr_word,
    input  logic [15:0]   tile_word,
    input  logic [15:0]   pos_word,
    input  logic          odd_frame,
    input  logic          screen_flip,
    output sed_pkg::dec_t dec
);
    import sed_pkg::*;

    logic [PART_W-1:0]       m;
    logic signed [SY_W-1:0]  x9;
    logic signed [SY_W-1:0]  y9;
    logic signed [SY_W-1:0]  x_norm;
    logic signed [SY_W-1:0]  y_norm;
    logic                    flash_drop;
    logic                    x_drop;

    always_comb
    begin
        unique case (attr_word[10:9])
            2'd0:    m = 3'd0;
            2'd1:    m = 3'd1;
            2'd2:    m = 3'd3;
            default: m = 3'd7;
        endcase
    end

    // Fold the 9-bit positions into signed range
    assign x9 = (pos_word[8:0] >= X_WRAP) ? {{2{1'b1}}, pos_word[8:0]}
                                          : {2'b00, pos_word[8:0]};
    assign y9 = (attr_word[8:0] >= Y_WRAP) ? {{2{1'b1}}, attr_word[8:0]}
                                           : {2'b00, attr_word[8:0]};
    assign x_norm = X_ORIGIN - x9;
    assign y_norm = Y_ORIGIN - y9;

    assign flash_drop = attr_word[12] & odd_frame;
    assign x_drop     = (x_norm > X_LIMIT);

    always_comb
    begin
        dec.drop     = flash_drop | x_drop;
        dec.flip     = screen_flip;
        dec.mirror_x = attr_word[13] ^ screen_flip;
        dec.mirror_y = attr_word[14] ^ screen_flip;
        dec.entry_fy = attr_word[14];
        dec.palette  = pos_word[13:9];
        case (pos_word[15:14])
            PRIO_LVL_NONE: dec.prio_mask = PRIO_MASK_NONE;
            PRIO_LVL_MID:  dec.prio_mask = PRIO_MASK_MID;
            default:       dec.prio_mask = PRIO_MASK_TOP;
        endcase
        dec.screen_x = screen_flip ? x9[SX_W-1:0] : x_norm[SX_W-1:0];
        dec.pos_y    = screen_flip ? y9 : y_norm;
        dec.base     = tile_word & ~{{(TILE_W-PART_W){1'b0}}, m};
        dec.last_idx = m;
    end

endmodule

FILE: sv/sprite_entry_decoder_unit.sv
`timescale 1ns / 1ps

// Sprite entry decoder.
// Slave stream: one transaction carries a three-word sprite entry in s_tdata
// and the frame parity in s_tuser. Master stream: one draw command per
// vertical part, top part first, with m_tlast on the final part.
// A sprite has 1, 2, 4 or 8 parts; a flashing sprite on an odd frame or one
// whose x is off the right edge produces no transaction at all.
// Timing: after an entry is taken the block forms the first part's y on its
// shared adder in a setup state, then emits one part per cycle while the
// output register is free; a dropped entry leaves the input ready.
// The same adder steps y by 16 for each further part.
// s_tready is low while parts are still being produced. The output register
// holds a command until m_tready; a stall there freezes the part sequence.
// The last command may still wait in the output register while the next
// entry is accepted.
// Reset clears the sequencer and output valid, and sets screen_flip to 1.
// cfg_wr_en writes screen_flip; it takes effect on the next accepted entry.
module sprite_entry_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // attr_word[15:0], tile_word[31:16], pos_word[47:32]
    input  logic        s_tuser,   // odd_frame[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // tile_code[15:0], palette[20:16], mirror_x[21],
                                   // mirror_y[22], screen_x[32:23], screen_y[43:33],
                                   // prio_mask[51:44], zero[55:52]
    output logic        m_tlast    // last_part
);
    import sed_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic                screen_flip_reg;
    dec_t                dec;
    dec_t                ent_reg, ent_next;
    logic [PART_W-1:0]   idx_reg, idx_next;
    logic [SY_W-1:0]     sy_reg, sy_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [TILE_W-1:0]   code_reg, code_next;
    logic [SY_W-1:0]     out_y_reg, out_y_next;
    logic                last_reg, last_next;
    logic [PAL_W-1:0]    pal_reg;
    logic                mx_reg, my_reg;
    logic [SX_W-1:0]     sx_reg;
    logic [PRIO_W-1:0]   prio_reg;

    logic                accept;
    logic                out_free;
    logic                emit;

    logic [SY_W-1:0]     add_a;
    logic [SY_W-1:0]     add_b;
    logic                add_neg;
    logic [SY_W-1:0]     add_sum;
    logic [PART_W-1:0]   part_off;

    sed_entry_decode u_dec (
        .attr_word   (s_tdata[15:0]),
        .tile_word   (s_tdata[31:16]),
        .pos_word    (s_tdata[47:32]),
        .odd_frame   (s_tuser),
        .screen_flip (screen_flip_reg),
        .dec         (dec)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign emit     = (state_reg == ST_EMIT) & out_free;

    // Shared adder: start y in setup, then step by one part pitch per command
    always_comb
    begin
        if (state_reg == ST_SETUP)
        begin
            add_a   = ent_reg.pos_y;
            add_b   = {{(SY_W-PART_W-4){1'b0}}, ent_reg.last_idx, 4'b0000};
            add_neg = ~ent_reg.flip;
        end
        else
        begin
            add_a   = sy_reg;
            add_b   = PART_PITCH;
            add_neg = ent_reg.flip;
        end
        add_sum = add_a + (add_b ^ {SY_W{add_neg}}) + {{(SY_W-1){1'b0}}, add_neg};
    end

    assign part_off = ent_reg.entry_fy ? idx_reg : (~idx_reg & ent_reg.last_idx);

    always_comb
    begin
        state_next    = state_reg;
        ent_next      = ent_reg;
        idx_next      = idx_reg;
        sy_next       = sy_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        code_next     = code_reg;
        out_y_next    = out_y_reg;
        last_next     = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !dec.drop)
                begin
                    ent_next   = dec;
                    idx_next   = dec.last_idx;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                sy_next    = add_sum;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    code_next     = ent_reg.base | {{(TILE_W-PART_W){1'b0}}, part_off};
                    out_y_next    = sy_reg;
                    last_next     = (idx_reg == '0);
                    sy_next       = add_sum;
                    idx_next      = idx_reg - PART_W'(1);
                    if (idx_reg == '0)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            screen_flip_reg <= 1'b1;
            m_tvalid_reg    <= 1'b0;
            idx_reg         <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            idx_reg      <= idx_next;
            if (cfg_wr_en)
                screen_flip_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg   <= ent_next;
        sy_reg    <= sy_next;
        code_reg  <= code_next;
        out_y_reg <= out_y_next;
        last_reg  <= last_next;
        if (emit)
        begin
            pal_reg  <= ent_reg.palette;
            mx_reg   <= ent_reg.mirror_x;
            my_reg   <= ent_reg.mirror_y;
            sx_reg   <= ent_reg.screen_x;
            prio_reg <= ent_reg.prio_mask;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0000, prio_reg, out_y_reg, sx_reg, my_reg, mx_reg,
                       pal_reg, code_reg};

    a_busy_after_entry: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !dec.drop |=> !s_tready)
        else $error("input still ready after a drawable entry");

    a_dropped_entry_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && dec.drop |=> s_tready)
        else $error("dropped entry started the part sequence");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit && idx_reg == '0 |=> s_tready && m_tvalid && m_tlast)
        else $error("final part did not return the sequencer to idle");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> idx_reg <= ent_reg.last_idx)
        else $error("part index beyond sprite height");

    a_setup_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SETUP |=> state_reg == ST_EMIT)
        else $error("setup did not advance to emission");

endmodule
